// ----- rtl/lru_page_replacement_assert.svh -----
// Assertion macros used by the page replacement top level.
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LRU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lru_page_replacement: assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define LRU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lru_page_replacement: assertion failed");

`endif

// ----- rtl/lru_pkg.sv -----
// Shared constants and types for the page replacement block.
`default_nettype none

package lru_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int unsigned MaxFramesDef = 32;
  localparam int unsigned PageBitsDef  = 16;

  // Fixed field widths, reset and minimum values.
  localparam int unsigned CfgW         = 6;
  localparam int unsigned FaultW       = 32;
  localparam int unsigned FrameRstVal  = 4;
  localparam int unsigned FrameMinVal  = 2;

  // Command broadcast from the top level to every cell of the row.
  typedef struct packed {
    logic step;   // A request is being applied this cycle.
    logic evict;  // Miss with the row full: every cell shifts down.
  } lru_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/lru_cell.sv -----
// One cell of the recency row: holds one resident page and shifts it downwards.
`default_nettype none

module lru_cell #(
  parameter int unsigned Idx      = 0,
  parameter int unsigned PageBits = 16,
  parameter int unsigned CntW     = 6
) (
  input  wire logic                 clk_i,
  input  wire lru_pkg::lru_cmd_t    cmd_i,
  input  wire logic [CntW-1:0]      count_i,
  input  wire logic [CntW-1:0]      wr_pos_i,
  input  wire logic [PageBits-1:0]  page_i,
  input  wire logic [PageBits-1:0]  upper_i,
  input  wire logic                 seen_i,
  output logic                      seen_o,
  output logic [PageBits-1:0]       entry_o
);
  import lru_pkg::*;

  logic [PageBits-1:0] entry_q, entry_d;
  logic                occupied;
  logic                match;
  logic                shift;
  logic                load;

  // The entry is meaningful only below the fill count.
  assign occupied = count_i > CntW'(Idx);
  assign match    = occupied && (entry_q == page_i);

  // Hit flag ripples upwards: this cell and all above it close the gap.
  assign seen_o = seen_i | match;

  assign shift = cmd_i.step && (cmd_i.evict || seen_o);
  assign load  = cmd_i.step && (wr_pos_i == CntW'(Idx));

  // The new most-recent page wins over the shift from the neighbour.
  always_comb begin
    entry_d = entry_q;
    if (load) begin
      entry_d = page_i;
    end else if (shift) begin
      entry_d = upper_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ----- rtl/lru_page_replacement.sv -----
// Top level of the least-recently-used page replacement block.
// Usage: each request on the input channel (in_valid_i / in_ready_o) carries one
// page number. Every request gives exactly one result on the output channel
// (out_valid_o / out_ready_i): hit, fault, evicted page (zero without a fault),
// occupancy after the request and the saturating fault total.
// A request accepted at a clock edge has its result in the output register after
// that edge. Throughput is one request per cycle while the receiver does not
// stall; the compare and shift run across the row of
// MAX_FRAMES cells, which all compare against the page in parallel.
// The frame count register is written through cfg_we_i / cfg_wdata_i; the user
// must write it only while the block is idle (not enforced). Values below two
// act as two, above MAX_FRAMES as MAX_FRAMES. Reset empties the row (fill count
// zero), clears the fault total and sets the frame count to four. Cell contents
// need no clearing: only cells below the fill count are compared or evicted.
// When the receiver stalls, the result stays in the output register and no
// further request is taken until it has been delivered.
`default_nettype none

module lru_page_replacement #(
  parameter int unsigned MAX_FRAMES = lru_pkg::MaxFramesDef,
  parameter int unsigned PAGE_BITS  = lru_pkg::PageBitsDef,
  parameter int unsigned CNT_W      = $clog2(MAX_FRAMES + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [lru_pkg::CfgW-1:0]    cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [PAGE_BITS-1:0]        page_number_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             hit_o,
  output logic                             fault_o,
  output logic [PAGE_BITS-1:0]             evicted_page_o,
  output logic [CNT_W-1:0]                 occupancy_o,
  output logic [lru_pkg::FaultW-1:0]       fault_count_o
);
  import lru_pkg::*;

  `include "lru_page_replacement_assert.svh"

  localparam int unsigned LimW = (CNT_W > CfgW) ? CNT_W : CfgW;

  logic [CfgW-1:0]      frame_count_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [FaultW-1:0]    fault_total_q, fault_total_d;
  logic                 out_valid_q, out_valid_d;
  logic                 hit_q, fault_q;
  logic [PAGE_BITS-1:0] evicted_q;

  logic                 accept;
  logic [LimW-1:0]      fc_ext, limit;
  logic                 full;
  logic                 hit;
  logic                 evict;
  logic [CNT_W-1:0]     wr_pos;
  lru_cmd_t             cmd;

  logic [PAGE_BITS-1:0] entry [MAX_FRAMES];
  logic [PAGE_BITS-1:0] upper [MAX_FRAMES];
  logic [MAX_FRAMES:0]  seen;

  // Output register parts the two channels.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Clamp the frame count into its legal range.
  assign fc_ext = LimW'(frame_count_q);
  always_comb begin
    limit = fc_ext;
    if (fc_ext < LimW'(FrameMinVal)) begin
      limit = LimW'(FrameMinVal);
    end else if (fc_ext > LimW'(MAX_FRAMES)) begin
      limit = LimW'(MAX_FRAMES);
    end
  end
  assign full = LimW'(count_q) >= limit;

  // Row of cells; the hit flag ripples from the least recent end upwards.
  assign seen[0] = 1'b0;
  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    if (g == MAX_FRAMES - 1) begin : g_top
      assign upper[g] = '0;
    end else begin : g_mid
      assign upper[g] = entry[g+1];
    end
    lru_cell #(
      .Idx      (g),
      .PageBits (PAGE_BITS),
      .CntW     (CNT_W)
    ) u_cell (
      .clk_i    (clk_i),
      .cmd_i    (cmd),
      .count_i  (count_q),
      .wr_pos_i (wr_pos),
      .page_i   (page_number_i),
      .upper_i  (upper[g]),
      .seen_i   (seen[g]),
      .seen_o   (seen[g+1]),
      .entry_o  (entry[g])
    );
  end

  assign hit   = seen[MAX_FRAMES];
  assign evict = !hit && full;

  assign cmd.step  = accept;
  assign cmd.evict = evict;

  // The new page goes to the most-recent end of the row.
  assign wr_pos = (hit || evict) ? (count_q - CNT_W'(1)) : count_q;

  // Fill count and fault total.
  always_comb begin
    count_d       = count_q;
    fault_total_d = fault_total_q;
    if (accept) begin
      if (!hit && !full) begin
        count_d = count_q + CNT_W'(1);
      end
      if (evict && (fault_total_q != {FaultW{1'b1}})) begin
        fault_total_d = fault_total_q + FaultW'(1);
      end
    end
  end

  // Result valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= CfgW'(FrameRstVal);
      count_q       <= '0;
      fault_total_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        frame_count_q <= cfg_wdata_i;
      end
      count_q       <= count_d;
      fault_total_q <= fault_total_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hit_q     <= hit;
      fault_q   <= evict;
      evicted_q <= evict ? entry[0] : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign fault_o        = fault_q;
  assign evicted_page_o = evicted_q;
  assign occupancy_o    = count_q;
  assign fault_count_o  = fault_total_q;

  // A result is never both a hit and a fault.
  `LRU_ASSERT_IMP(a_hit_xor_fault, out_valid_q, !(hit_q && fault_q))
  // The fill count never exceeds the number of cells.
  `LRU_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_FRAMES))
  // An eviction leaves the occupancy unchanged.
  `LRU_ASSERT_NXT(a_evict_keeps_count, accept && evict, count_q == $past(count_q))
  // The fault total never decreases.
  `LRU_ASSERT_NXT(a_fault_monotonic, 1'b1, fault_total_q >= $past(fault_total_q))

endmodule

`default_nettype wire
